// ===== design/aapt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the axis-angle point transform.
// Used by aapt_matrix and axis_angle_point_transform_top; depends on nothing.
package aapt_pkg;

	// Field formats: coordinates Q16.16, coefficients Q2.14.
	localparam int COORD_W    = 32;
	localparam int COEF_W     = 16;
	localparam int FRAC       = COEF_W - 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COORD_W;

	// Internal widths, sized so that no intermediate can wrap.
	localparam int Q_W    = 2 * COEF_W - FRAC;
	localparam int OMC_W  = COEF_W + 1;
	localparam int R_W    = Q_W + OMC_W - FRAC;
	localparam int M_W    = R_W + 1;
	localparam int PROD_W = COORD_W + M_W;
	localparam int ACC_W  = PROD_W + 2;

	// Register stages in the matrix builder, and the width of the settle counter for the hold-off after a write.
	localparam int MAT_LAT  = 3;
	localparam int SETTLE_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_X  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_COS     = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_SIN     = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = CFG_IDX_W'(7);

	// Fixed-point one in the coefficient format.
	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC);

	typedef struct packed {
		logic signed [COORD_W-1:0] in_x;
		logic signed [COORD_W-1:0] in_y;
		logic signed [COORD_W-1:0] in_z;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
	} out_item_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] axis_x;
		logic signed [COEF_W-1:0] axis_y;
		logic signed [COEF_W-1:0] axis_z;
		logic signed [COEF_W-1:0] cos_angle;
		logic signed [COEF_W-1:0] sin_angle;
	} coef_cfg_t;

	typedef logic signed [M_W-1:0] melem_t;
	typedef melem_t [2:0][2:0] mat_t;

endpackage

// ===== design/aapt_matrix.sv =====
`timescale 1ns / 1ps
// Rodrigues rotation matrix builder: three register stages from axis, cos, sin.
// Depends on aapt_pkg.
module aapt_matrix
	import aapt_pkg::*;
(
	input  logic      clk,
	input  coef_cfg_t coef,
	output mat_t      mat
);

	localparam int PI [6] = '{0, 1, 2, 0, 0, 1};
	localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};
	localparam logic signed [2*COEF_W-1:0]    RND_A = (2*COEF_W)'(1 << (FRAC - 1));
	localparam logic signed [Q_W+OMC_W-1:0]   RND_B = (Q_W + OMC_W)'(1 << (FRAC - 1));
	localparam logic signed [OMC_W-1:0]       ONE_OMC = OMC_W'(1 << FRAC);

	logic signed [COEF_W-1:0]      axis [3];
	logic signed [2*COEF_W-1:0]    aa [6];
	logic signed [2*COEF_W-1:0]    asp [3];
	logic signed [OMC_W-1:0]       omc;
	logic signed [Q_W+OMC_W-1:0]   rp [6];

	// Stage A: axis products and the sine terms.
	logic signed [Q_W-1:0]    sq_q [6];
	logic signed [Q_W-1:0]    u_q [3];
	logic signed [OMC_W-1:0]  omc_q;
	logic signed [COEF_W-1:0] c_a_q;

	// Stage B: outer-product terms scaled by one minus cosine.
	logic signed [R_W-1:0]    r_q [6];
	logic signed [Q_W-1:0]    ub_q [3];
	logic signed [COEF_W-1:0] c_b_q;

	// Stage C: finished matrix.
	mat_t m_q;

	assign axis[0] = coef.axis_x;
	assign axis[1] = coef.axis_y;
	assign axis[2] = coef.axis_z;
	assign omc     = ONE_OMC - OMC_W'(coef.cos_angle);

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			aa[k] = axis[PI[k]] * axis[PJ[k]];
			rp[k] = sq_q[k] * omc_q;
		end
		for (int k = 0; k < 3; k++) begin
			asp[k] = axis[k] * coef.sin_angle;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			sq_q[k] <= Q_W'((aa[k] + RND_A) >>> FRAC);
			r_q[k]  <= R_W'((rp[k] + RND_B) >>> FRAC);
		end
		for (int k = 0; k < 3; k++) begin
			u_q[k]  <= Q_W'((asp[k] + RND_A) >>> FRAC);
			ub_q[k] <= u_q[k];
		end
		omc_q <= omc;
		c_a_q <= coef.cos_angle;
		c_b_q <= c_a_q;

		// Pair order in r_q: xx, yy, zz, xy, xz, yz. Sine terms in ub_q: x, y, z.
		m_q[0][0] <= M_W'(r_q[0]) + M_W'(c_b_q);
		m_q[0][1] <= M_W'(r_q[3]) - M_W'(ub_q[2]);
		m_q[0][2] <= M_W'(r_q[4]) + M_W'(ub_q[1]);
		m_q[1][0] <= M_W'(r_q[3]) + M_W'(ub_q[2]);
		m_q[1][1] <= M_W'(r_q[1]) + M_W'(c_b_q);
		m_q[1][2] <= M_W'(r_q[5]) - M_W'(ub_q[0]);
		m_q[2][0] <= M_W'(r_q[4]) - M_W'(ub_q[1]);
		m_q[2][1] <= M_W'(r_q[5]) + M_W'(ub_q[0]);
		m_q[2][2] <= M_W'(r_q[2]) + M_W'(c_b_q);
	end

	assign mat = m_q;

endmodule

// ===== design/axis_angle_point_transform_top.sv =====
`timescale 1ns / 1ps
// Top level of the axis-angle point transform: config registers and point pipeline.
// Depends on aapt_pkg and aapt_matrix.

// Each beat on the input carries one Q16.16 point; the block returns R*p + t,
// rounded to nearest and saturated, one result beat per input beat in order.
// The point path is four register stages (input, nine 32x22 products, partial
// sums, final sum with rounding and saturation); one point is taken every cycle
// while the output drains and the matrix is not settling. The rotation matrix
// is rebuilt from the registers by a separate three-stage unit; after reset and
// after every register write, in_ready stays low while that unit settles.
// Write registers only while no points are in flight.
module axis_angle_point_transform_top
	import aapt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [SETTLE_W-1:0]     SETTLE_INIT = SETTLE_W'(MAT_LAT - 1);
	localparam logic [FRAC-1:0]         HALF_LSB    = FRAC'(1 << (FRAC - 1));
	localparam logic signed [COORD_W-1:0] SAT_MAX   = {1'b0, {(COORD_W - 1){1'b1}}};
	localparam logic signed [COORD_W-1:0] SAT_MIN   = {1'b1, {(COORD_W - 1){1'b0}}};

	coef_cfg_t                 coef_q;
	logic signed [COORD_W-1:0] shift_q [3];
	logic [SETTLE_W-1:0]       settle_q;
	mat_t                      mat;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	in_item_t                  pt_s1;
	logic signed [PROD_W-1:0]  prod_s2 [3][3];
	logic signed [ACC_W-1:0]   sa_s3 [3];
	logic signed [ACC_W-1:0]   sb_s3 [3];
	logic signed [COORD_W-1:0] res_s4 [3];

	logic signed [COORD_W-1:0] pt [3];
	logic signed [PROD_W-1:0]  pm [3][3];
	logic signed [ACC_W-1:0]   tterm [3];
	logic signed [ACC_W-1:0]   tot [3];
	logic signed [ACC_W-1:0]   sh [3];
	logic signed [COORD_W-1:0] res [3];

	// Configuration registers and the matrix settle counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.axis_x    <= '0;
			coef_q.axis_y    <= '0;
			coef_q.axis_z    <= COEF_ONE;
			coef_q.cos_angle <= COEF_ONE;
			coef_q.sin_angle <= '0;
			shift_q[0]       <= '0;
			shift_q[1]       <= '0;
			shift_q[2]       <= '0;
			settle_q         <= SETTLE_INIT;
		end else begin
			if (cfg_we) begin
				settle_q <= SETTLE_INIT;
				unique case (cfg_index)
					REG_AXIS_X:  coef_q.axis_x    <= cfg_data[COEF_W-1:0];
					REG_AXIS_Y:  coef_q.axis_y    <= cfg_data[COEF_W-1:0];
					REG_AXIS_Z:  coef_q.axis_z    <= cfg_data[COEF_W-1:0];
					REG_COS:     coef_q.cos_angle <= cfg_data[COEF_W-1:0];
					REG_SIN:     coef_q.sin_angle <= cfg_data[COEF_W-1:0];
					REG_SHIFT_X: shift_q[0]       <= cfg_data[COORD_W-1:0];
					REG_SHIFT_Y: shift_q[1]       <= cfg_data[COORD_W-1:0];
					REG_SHIFT_Z: shift_q[2]       <= cfg_data[COORD_W-1:0];
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_W'(1);
			end
		end
	end

	aapt_matrix u_matrix (
		.clk  (clk),
		.coef (coef_q),
		.mat  (mat)
	);

	// Each stage takes a new beat when it is empty or its successor moves.
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1 && (settle_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid && in_ready;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	assign pt[0] = pt_s1.in_x;
	assign pt[1] = pt_s1.in_y;
	assign pt[2] = pt_s1.in_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				pm[i][j] = pt[j] * $signed(mat[i][j]);
			end
			// The translation is pre-scaled by one coefficient unit, with the
			// rounding half folded into its empty low bits.
			tterm[i] = {{(ACC_W - COORD_W - FRAC){shift_q[i][COORD_W-1]}}, shift_q[i], HALF_LSB};
			tot[i]   = sa_s3[i] + sb_s3[i];
			sh[i]    = tot[i] >>> FRAC;
			if (&sh[i][ACC_W-1:COORD_W-1] || ~|sh[i][ACC_W-1:COORD_W-1]) begin
				res[i] = sh[i][COORD_W-1:0];
			end else begin
				res[i] = sh[i][ACC_W-1] ? SAT_MIN : SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pt_s1 <= in_item;
		end
		if (en2) begin
			prod_s2 <= pm;
		end
		if (en3) begin
			for (int i = 0; i < 3; i++) begin
				sa_s3[i] <= ACC_W'(prod_s2[i][0]) + ACC_W'(prod_s2[i][1]);
				sb_s3[i] <= ACC_W'(prod_s2[i][2]) + tterm[i];
			end
		end
		if (en4) begin
			res_s4 <= res;
		end
	end

	assign out_valid      = v_s4;
	assign out_item.out_x = res_s4[0];
	assign out_item.out_y = res_s4[1];
	assign out_item.out_z = res_s4[2];

`ifndef SYNTHESIS
	// No point may enter while the matrix is being rebuilt after a write.
	a_settle_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("point accepted right after a register write");

	// A beat held in the sum stage is not dropped while the output stalls.
	a_sum_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en3 |=> v_s3)
		else $error("sum stage lost a stalled beat");

	// A product beat always advances into the sum stage when that stage is free.
	a_product_advances: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && en3 |=> v_s3)
		else $error("product beat did not advance");

	// With nothing behind it, a delivered result is not shown again.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !v_s3 |=> !out_valid)
		else $error("result beat repeated");
`endif

endmodule

// ===== tb/sv/aapt_point_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the axis-angle point transform: mirrors the register writes,
// predicts every transformed point and compares the result beats in order.
// Depends on aapt_pkg.
module aapt_point_checker
	import aapt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_item,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	coef_cfg_t                 coefs;
	logic signed [COORD_W-1:0] shift [3];
	out_item_t                 expected_points [$];
	out_item_t                 want;

	function automatic longint round_frac(longint v);
		return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
		longint hi_lim;
		longint lo_lim;
		hi_lim = (longint'(1) << (COORD_W - 1)) - 1;
		lo_lim = -hi_lim - 1;
		if (v > hi_lim)
			v = hi_lim;
		else if (v < lo_lim)
			v = lo_lim;
		return COORD_W'(v);
	endfunction

	// Rotation about the axis with the Rodrigues matrix, then the shift. Each
	// matrix entry is rounded in the coefficient format; the row sums are exact.
	function automatic out_item_t transform_point(in_item_t pt);
		longint ax, ay, az, c, s, omc;
		longint rxx, ryy, rzz, rxy, rxz, ryz, ux, uy, uz;
		longint m [3][3];
		longint p [3];
		longint acc;
		logic signed [COORD_W-1:0] res [3];
		out_item_t r;
		ax = longint'($signed(coefs.axis_x));
		ay = longint'($signed(coefs.axis_y));
		az = longint'($signed(coefs.axis_z));
		c = longint'($signed(coefs.cos_angle));
		s = longint'($signed(coefs.sin_angle));
		omc = (longint'(1) << FRAC) - c;
		rxx = round_frac(round_frac(ax * ax) * omc);
		ryy = round_frac(round_frac(ay * ay) * omc);
		rzz = round_frac(round_frac(az * az) * omc);
		rxy = round_frac(round_frac(ax * ay) * omc);
		rxz = round_frac(round_frac(ax * az) * omc);
		ryz = round_frac(round_frac(ay * az) * omc);
		ux = round_frac(ax * s);
		uy = round_frac(ay * s);
		uz = round_frac(az * s);
		m[0][0] = rxx + c;
		m[0][1] = rxy - uz;
		m[0][2] = rxz + uy;
		m[1][0] = rxy + uz;
		m[1][1] = ryy + c;
		m[1][2] = ryz - ux;
		m[2][0] = rxz - uy;
		m[2][1] = ryz + ux;
		m[2][2] = rzz + c;
		p[0] = longint'($signed(pt.in_x));
		p[1] = longint'($signed(pt.in_y));
		p[2] = longint'($signed(pt.in_z));
		for (int i = 0; i < 3; i++) begin
			acc = longint'($signed(shift[i])) * (longint'(1) << FRAC);
			for (int j = 0; j < 3; j++)
				acc += p[j] * m[i][j];
			res[i] = clamp_coord(round_frac(acc));
		end
		r.out_x = res[0];
		r.out_y = res[1];
		r.out_z = res[2];
		return r;
	endfunction

	task automatic report(input string msg);
		fail_count++;
		$display("[%0t] %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs = '0;
			coefs.axis_z = COEF_ONE;
			coefs.cos_angle = COEF_ONE;
			foreach (shift[i])
				shift[i] = '0;
			expected_points.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_AXIS_X:  coefs.axis_x = cfg_data[COEF_W-1:0];
					REG_AXIS_Y:  coefs.axis_y = cfg_data[COEF_W-1:0];
					REG_AXIS_Z:  coefs.axis_z = cfg_data[COEF_W-1:0];
					REG_COS:     coefs.cos_angle = cfg_data[COEF_W-1:0];
					REG_SIN:     coefs.sin_angle = cfg_data[COEF_W-1:0];
					REG_SHIFT_X: shift[0] = cfg_data[COORD_W-1:0];
					REG_SHIFT_Y: shift[1] = cfg_data[COORD_W-1:0];
					REG_SHIFT_Z: shift[2] = cfg_data[COORD_W-1:0];
				endcase
			end
			// The output beat is matched before this edge's input beat is queued,
			// since a point cannot come out in the cycle it goes in.
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					report($sformatf("result beat %h with no point outstanding", out_item));
				end else begin
					want = expected_points.pop_front();
					if (out_item.out_x !== want.out_x)
						report($sformatf("out_x got %h expected %h", out_item.out_x, want.out_x));
					if (out_item.out_y !== want.out_y)
						report($sformatf("out_y got %h expected %h", out_item.out_y, want.out_y));
					if (out_item.out_z !== want.out_z)
						report($sformatf("out_z got %h expected %h", out_item.out_z, want.out_z));
				end
			end
			if (in_valid && in_ready)
				expected_points = {expected_points, transform_point(in_item)};
			pending = expected_points.size();
		end
	end

endmodule

// ===== tb/sv/axis_angle_point_transform_top_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the axis-angle point transform: corner points under
// extreme settings, then random phases with sender gaps and receiver stalls.
// Depends on aapt_pkg, axis_angle_point_transform_top and aapt_point_checker.
module axis_angle_point_transform_top_test;
	import aapt_pkg::*;

	localparam int DIRECTED_PER_SET = 8;
	localparam int RANDOM_PHASES    = 8;
	localparam int POINTS_PER_PHASE = 56;
	localparam int SETTLE_CYCLES    = 8;
	localparam int DRAIN_LIMIT      = 20000;
	localparam int HOLD_CYCLES      = 150;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int holds_asked   = 0;
	int holds_taken   = 0;
	int hold_left     = 0;

	axis_angle_point_transform_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	aapt_point_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_taken != holds_asked) begin
				holds_taken = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Offers one point, with random idle cycles first; returns at the falling
	// edge after the beat was taken, with valid still high.
	task automatic send_point(input in_item_t pt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= pt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering and waits until every point in flight has come back or the drain limit runs out.
	task automatic settle_idle();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write enable stays high across back-to-back writes; the caller lowers it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// The unused upper bits of the coefficient writes carry junk on purpose.
	task automatic load_config(input coef_cfg_t cc, input logic [COORD_W-1:0] sx,
			input logic [COORD_W-1:0] sy, input logic [COORD_W-1:0] sz);
		settle_idle();
		write_reg(REG_AXIS_X, {(CFG_DATA_W - COEF_W)'($urandom()), cc.axis_x});
		write_reg(REG_AXIS_Y, {(CFG_DATA_W - COEF_W)'($urandom()), cc.axis_y});
		write_reg(REG_AXIS_Z, {(CFG_DATA_W - COEF_W)'($urandom()), cc.axis_z});
		write_reg(REG_COS, {(CFG_DATA_W - COEF_W)'($urandom()), cc.cos_angle});
		write_reg(REG_SIN, {(CFG_DATA_W - COEF_W)'($urandom()), cc.sin_angle});
		write_reg(REG_SHIFT_X, sx);
		write_reg(REG_SHIFT_Y, sy);
		write_reg(REG_SHIFT_Z, sz);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(5))
			0, 1: return $urandom();
			2, 3: return COORD_W'($signed(21'($urandom())));
			default: begin
				case ($urandom_range(5))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					3: return 32'h0000_0000;
					4: return 32'h0001_0000;
					default: return 32'hFFFF_0000;
				endcase
			end
		endcase
	endfunction

	initial begin
		in_item_t corner_pts [DIRECTED_PER_SET];
		in_item_t pt;
		coef_cfg_t cc;
		logic [COORD_W-1:0] sx, sy, sz;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		corner_pts[0] = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
		corner_pts[1] = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		corner_pts[2] = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		corner_pts[3] = {32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
		corner_pts[4] = {32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000};
		corner_pts[5] = {32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
		corner_pts[6] = {32'h0000_2000, 32'hFFFF_E000, 32'h7FFF_0000};
		corner_pts[7] = {$urandom(), $urandom(), $urandom()};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Corner points under the reset identity, then under two extreme
		// settings where the axis is far from unit length and the cosine and
		// sine do not belong together, so products and sums saturate.
		for (int set = 0; set < 3; set++) begin
			if (set == 1) begin
				cc.axis_x = 16'sh8000;
				cc.axis_y = 16'sh8000;
				cc.axis_z = 16'sh8000;
				cc.cos_angle = 16'sh8000;
				cc.sin_angle = 16'sh8000;
				load_config(cc, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
			end else if (set == 2) begin
				cc.axis_x = 16'sh7FFF;
				cc.axis_y = 16'sh7FFF;
				cc.axis_z = 16'sh7FFF;
				cc.cos_angle = 16'sh7FFF;
				cc.sin_angle = 16'sh7FFF;
				load_config(cc, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
			end
			for (int k = 0; k < DIRECTED_PER_SET; k++)
				send_point(corner_pts[k]);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase % 2 == 0) begin
				// Proper rotations: unit axes and matching cosine and sine.
				cc = '0;
				case ($urandom_range(4))
					0: cc.axis_x = COEF_ONE;
					1: cc.axis_y = COEF_ONE;
					2: cc.axis_z = COEF_ONE;
					3: begin
						cc.axis_x = 16'sd9459;
						cc.axis_y = 16'sd9459;
						cc.axis_z = 16'sd9459;
					end
					default: begin
						cc.axis_y = -16'sd11585;
						cc.axis_z = 16'sd11585;
					end
				endcase
				case ($urandom_range(5))
					0: cc.cos_angle = COEF_ONE;
					1: cc.sin_angle = COEF_ONE;
					2: cc.cos_angle = -COEF_ONE;
					3: begin
						cc.cos_angle = 16'sd11585;
						cc.sin_angle = 16'sd11585;
					end
					4: begin
						cc.cos_angle = 16'sd14189;
						cc.sin_angle = -16'sd8192;
					end
					default: cc.sin_angle = -COEF_ONE;
				endcase
				sx = COORD_W'($signed(24'($urandom())));
				sy = COORD_W'($signed(24'($urandom())));
				sz = COORD_W'($signed(24'($urandom())));
			end else begin
				cc = {$urandom(), $urandom(), 16'($urandom())};
				sx = $urandom();
				sy = $urandom();
				sz = $urandom();
			end
			load_config(cc, sx, sy, sz);

			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 71;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 71;
				end
				default: begin
					send_idle_pct = 9;
					stall_pct = 9;
				end
			endcase

			for (int k = 0; k < POINTS_PER_PHASE; k++) begin
				// Back the pipeline up against a stopped receiver.
				if (phase % 4 == 0 && k == 20)
					holds_asked++;
				pt.in_x = pick_coord();
				pt.in_y = pick_coord();
				pt.in_z = pick_coord();
				send_point(pt);
			end
		end

		settle_idle();
		if (pending != 0)
			$display("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
